FILE: rtl/core/atbtp_pkg.sv
// shared constants, register index codes and the tile bound table for the
// attention batch tile planner; no dependencies
package atbtp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_HEAD_COUNT    = 3'd0;
  localparam logic [2:0] REG_HEAD_DIM      = 3'd1;
  localparam logic [2:0] REG_KV_HEAD_COUNT = 3'd2;
  localparam logic [2:0] REG_PAGED_KV      = 3'd3;
  localparam logic [2:0] REG_PAGE_LEN      = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned LEN_W      = 20;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 168;

  // divider: 22-bit dividend shift register, 13-bit divisor, two bits a cycle
  localparam int unsigned DIV_W      = 22;
  localparam int unsigned DEN_W      = 13;
  localparam int unsigned DIV_STEPS  = DIV_W / 2;
  localparam int unsigned DIV_CNT_W  = 4;

  // multiplier operand widths
  localparam int unsigned MUL_A_W = 29;
  localparam int unsigned MUL_B_W = 13;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // floor(64 / w) for a width in 16-element units, w = 1..64
  function automatic logic [6:0] quot64(input logic [6:0] w);
    logic [6:0] q;
    case (w) inside
      7'd1:              q = 7'd64;
      7'd2:              q = 7'd32;
      7'd3:              q = 7'd21;
      7'd4:              q = 7'd16;
      7'd5:              q = 7'd12;
      7'd6:              q = 7'd10;
      7'd7:              q = 7'd9;
      7'd8:              q = 7'd8;
      7'd9:              q = 7'd7;
      7'd10:             q = 7'd6;
      [7'd11:7'd12]:     q = 7'd5;
      [7'd13:7'd16]:     q = 7'd4;
      [7'd17:7'd21]:     q = 7'd3;
      [7'd22:7'd32]:     q = 7'd2;
      [7'd33:7'd64]:     q = 7'd1;
      default:           q = 7'd0;
    endcase
    return q;
  endfunction

endpackage

FILE: rtl/core/attention_batch_tile_planner.sv
// attention batch tile planner top level: tile choice, block count and
// running element offsets per batch entry; depends on atbtp_pkg
module attention_batch_tile_planner (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [atbtp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [atbtp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input words
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [atbtp_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // q_len, kv_len
  input  logic                                  s_axis_tuser,  // start_batch
  // result words
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tile_rows, tile_cols, entry_blocks, blocks_total, q_offset, kv_base_ofs, zero pad
  output logic [atbtp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tuser   // active
);

  // One word per batch entry. After a word is taken the planner works on it
  // and is not ready until its result has moved into the output register, so
  // it takes no new word before the last is done. The time is set by one
  // shared restoring divider that retires two quotient bits a cycle and runs
  // twice per word: once for the query block count ceil(q_len / tile_rows)
  // and once for rounding kv_len up to whole pages. One shared 29x13 multiplier
  // then forms the page span and the two offset advances in turn. The tile
  // width comes from the head dimension and the rounded kv length, the tile
  // height from the wider of head dimension and tile width and the rounded q
  // length, both through a small constant table. Results sit in an output
  // register, so the next word is taken while a result waits. start_batch on
  // a word clears the offsets and block total before it. Offsets wrap at 2^48,
  // the block total at 2^32. The user must see that configuration is written
  // only while the planner is idle; the planner does not enforce it.

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_COLS     = 4'd1;
  localparam logic [3:0] S_ROWS     = 4'd2;
  localparam logic [3:0] S_DIV_Q    = 4'd3;
  localparam logic [3:0] S_DIV_KV   = 4'd4;
  localparam logic [3:0] S_MUL_SPAN = 4'd5;
  localparam logic [3:0] S_MUL_QH   = 4'd6;
  localparam logic [3:0] S_MUL_QD   = 4'd7;
  localparam logic [3:0] S_MUL_KH   = 4'd8;
  localparam logic [3:0] S_MUL_KD   = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  // configuration registers
  logic [7:0]  head_count_q;
  logic [9:0]  head_dim_q;
  logic [7:0]  kv_head_count_q;
  logic        paged_kv_q;
  logic [12:0] page_len_q;

  // sequencer and per-word registers
  logic [3:0]  state_q, state_d;
  logic [19:0] q_len_q, kv_len_q;
  logic [8:0]  cols_q;
  logic [7:0]  rows_q;
  logic [16:0] blocks_q;
  logic        act_q;
  logic [20:0] span_q;
  logic [37:0] q_add_q;

  // running state
  logic [47:0] q_acc_q, kv_acc_q;
  logic [31:0] block_sum_q;

  // shared divider
  logic [atbtp_pkg::DIV_W-1:0]     div_sh_q;
  logic [atbtp_pkg::DEN_W-1:0]     div_rem_q, div_den_q;
  logic [atbtp_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [atbtp_pkg::DIV_W-1:0]     div_sh2;
  logic [atbtp_pkg::DEN_W-1:0]     div_rem2;
  logic                            div_last;

  // shared multiplier
  logic [atbtp_pkg::MUL_A_W-1:0] mul_a;
  logic [atbtp_pkg::MUL_B_W-1:0] mul_b;
  logic [atbtp_pkg::MUL_P_W-1:0] mul_p_q;

  // output register
  logic         out_valid_q;
  logic [7:0]   out_rows_q;
  logic [8:0]   out_cols_q;
  logic [16:0]  out_blocks_q;
  logic [31:0]  out_total_q;
  logic [47:0]  out_qofs_q, out_kvofs_q;
  logic         out_act_q;

  logic in_acc, out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // ---------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_count_q    <= 8'd1;
      head_dim_q      <= 10'd128;
      kv_head_count_q <= 8'd1;
      paged_kv_q      <= 1'b1;
      page_len_q      <= 13'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atbtp_pkg::REG_HEAD_COUNT:    head_count_q    <= cfg_wdata_i[7:0];
        atbtp_pkg::REG_HEAD_DIM:      head_dim_q      <= cfg_wdata_i[9:0];
        atbtp_pkg::REG_KV_HEAD_COUNT: kv_head_count_q <= cfg_wdata_i[7:0];
        atbtp_pkg::REG_PAGED_KV:      paged_kv_q      <= cfg_wdata_i[0];
        atbtp_pkg::REG_PAGE_LEN:      page_len_q      <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // tile choice, all widths in 16-element units
  // ---------------------------------------------------------------------
  logic [10:0] d_sum;
  logic [6:0]  d16, kdim16, ncap16, nb16, cols16;
  logic [20:0] kv_sum, q_sum;
  logic [16:0] kv16, q16;
  logic [6:0]  wide16, mcap16, mb16, rows16;
  logic [8:0]  cols_new;
  logic [7:0]  rows_new;

  always_comb begin
    d_sum  = {1'b0, head_dim_q} + 11'd15;
    d16    = d_sum[10:4];
    // head dimension below 128 still sizes the key tile as 128
    kdim16 = (d16 < 7'd8) ? 7'd8 : d16;
    ncap16 = atbtp_pkg::quot64(kdim16);
    kv_sum = {1'b0, kv_len_q} + 21'd15;
    kv16   = kv_sum[20:4];
    nb16   = (kv16 < {10'b0, ncap16}) ? kv16[6:0] : ncap16;
    // empty kv length falls back to the smallest tile
    cols16   = (nb16 == 7'd0) ? 7'd1 : nb16;
    cols_new = {cols16[4:0], 4'b0};

    wide16 = (d16 > {2'b0, cols_q[8:4]}) ? d16 : {2'b0, cols_q[8:4]};
    mcap16 = atbtp_pkg::quot64(wide16);
    q_sum  = {1'b0, q_len_q} + 21'd15;
    q16    = q_sum[20:4];
    mb16   = (q16 < {10'b0, mcap16}) ? q16[6:0] : mcap16;
    if (mb16 == 7'd0) begin
      rows16 = 7'd1;
    end else if (mb16 > 7'd8) begin
      rows16 = 7'd8;
    end else begin
      rows16 = mb16;
    end
    rows_new = {rows16[3:0], 4'b0};
  end

  // ---------------------------------------------------------------------
  // divider: two restoring steps per cycle
  // ---------------------------------------------------------------------
  always_comb begin
    logic [13:0] r1, r2;
    logic        g1, g2;
    logic [12:0] rem1;
    logic [21:0] sh1;
    r1       = {div_rem_q, div_sh_q[21]};
    g1       = (r1 >= {1'b0, div_den_q});
    rem1     = g1 ? 13'(r1 - {1'b0, div_den_q}) : r1[12:0];
    sh1      = {div_sh_q[20:0], g1};
    r2       = {rem1, sh1[21]};
    g2       = (r2 >= {1'b0, div_den_q});
    div_rem2 = g2 ? 13'(r2 - {1'b0, div_den_q}) : r2[12:0];
    div_sh2  = {sh1[20:0], g2};
  end

  assign div_last = (div_cnt_q == atbtp_pkg::DIV_CNT_W'(atbtp_pkg::DIV_STEPS - 1));

  // page rounding applies only with paging on and a nonzero page length
  logic        use_page;
  logic [20:0] q_dividend, kv_dividend;

  assign use_page    = paged_kv_q && (page_len_q != 13'd0);
  assign q_dividend  = 21'({1'b0, q_len_q} + {13'b0, rows_new} - 21'd1);
  assign kv_dividend = use_page ? 21'({1'b0, kv_len_q} + {8'b0, page_len_q} - 21'd1)
                                : {1'b0, kv_len_q};

  // ---------------------------------------------------------------------
  // multiplier operand select
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL_SPAN: begin
        mul_a = {8'b0, div_sh_q[20:0]};
        mul_b = div_den_q;
      end
      S_MUL_QH: begin
        mul_a = {9'b0, q_len_q};
        mul_b = {5'b0, head_count_q};
      end
      S_MUL_QD: begin
        mul_a = mul_p_q[28:0];
        mul_b = {3'b0, head_dim_q};
      end
      S_MUL_KH: begin
        mul_a = {8'b0, span_q};
        mul_b = {5'b0, kv_head_count_q};
      end
      S_MUL_KD: begin
        mul_a = mul_p_q[28:0];
        mul_b = {3'b0, head_dim_q};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_acc) state_d = S_COLS;
      S_COLS:     state_d = S_ROWS;
      S_ROWS:     state_d = S_DIV_Q;
      S_DIV_Q:    if (div_last) state_d = S_DIV_KV;
      S_DIV_KV:   if (div_last) state_d = S_MUL_SPAN;
      S_MUL_SPAN: state_d = S_MUL_QH;
      S_MUL_QH:   state_d = S_MUL_QD;
      S_MUL_QD:   state_d = S_MUL_KH;
      S_MUL_KH:   state_d = S_MUL_KD;
      S_MUL_KD:   state_d = S_OUT;
      S_OUT:      if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      q_acc_q     <= '0;
      kv_acc_q    <= '0;
      block_sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if ((state_q == S_DIV_Q) || (state_q == S_DIV_KV)) begin
        div_cnt_q <= div_last ? '0 : div_cnt_q + 1'b1;
      end

      if (in_acc && s_axis_tuser) begin
        q_acc_q     <= '0;
        kv_acc_q    <= '0;
        block_sum_q <= '0;
      end else if (out_load) begin
        q_acc_q     <= q_acc_q + {10'b0, q_add_q};
        kv_acc_q    <= kv_acc_q + {9'b0, mul_p_q[38:0]};
        block_sum_q <= block_sum_q + {15'b0, blocks_q};
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      q_len_q  <= s_axis_tdata[19:0];
      kv_len_q <= s_axis_tdata[39:20];
    end
    if (state_q == S_COLS) begin
      cols_q <= cols_new;
    end
    if (state_q == S_ROWS) begin
      rows_q    <= rows_new;
      act_q     <= (q_len_q != 20'd0) && (kv_len_q != 20'd0);
      div_sh_q  <= {1'b0, q_dividend};
      div_rem_q <= '0;
      div_den_q <= {5'b0, rows_new};
    end else if ((state_q == S_DIV_Q) && div_last) begin
      blocks_q  <= act_q ? div_sh2[16:0] : 17'd0;
      div_sh_q  <= {1'b0, kv_dividend};
      div_rem_q <= '0;
      div_den_q <= use_page ? page_len_q : 13'd1;
    end else if ((state_q == S_DIV_Q) || (state_q == S_DIV_KV)) begin
      div_sh_q  <= div_sh2;
      div_rem_q <= div_rem2;
    end

    if ((state_q == S_MUL_SPAN) || (state_q == S_MUL_QH) || (state_q == S_MUL_QD) ||
        (state_q == S_MUL_KH) || (state_q == S_MUL_KD)) begin
      mul_p_q <= mul_a * mul_b;
    end
    if (state_q == S_MUL_QH) begin
      span_q <= mul_p_q[20:0];
    end
    if (state_q == S_MUL_KH) begin
      q_add_q <= mul_p_q[37:0];
    end

    if (out_load) begin
      out_rows_q   <= rows_q;
      out_cols_q   <= cols_q;
      out_blocks_q <= blocks_q;
      out_total_q  <= block_sum_q + {15'b0, blocks_q};
      out_qofs_q   <= q_acc_q;
      out_kvofs_q  <= kv_acc_q;
      out_act_q    <= act_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_kvofs_q, out_qofs_q, out_total_q, out_blocks_q,
                          out_cols_q, out_rows_q};
  assign m_axis_tuser  = out_act_q;

`ifndef NO_ASSERTIONS
  // a start word clears the running state before the entry is worked on
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> (q_acc_q == '0 && kv_acc_q == '0 && block_sum_q == '0))
    else $error("start word did not clear running state");

  // an active entry always has at least one block, an idle one none
  a_blocks_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_blocks_q != 17'd0) == out_act_q))
    else $error("block count disagrees with active flag");

  // tile height is a nonzero multiple of 16 no larger than 128
  a_rows_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rows_q[3:0] == 4'd0 && out_rows_q != 8'd0 && out_rows_q <= 8'd128))
    else $error("tile height out of range");
`endif

endmodule
